/* design/timeout_event_table_core_assert.svh */
// assertion macros shared by the timeout event table checker
`ifndef TIMEOUT_EVENT_TABLE_CORE_ASSERT_SVH
`define TIMEOUT_EVENT_TABLE_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TET_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tet_pkg.sv */
// shared types, constants and helpers of the timeout event table
package tet_pkg;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned HANDLER_W   = 8;
  localparam int unsigned ARG_W       = 32;
  localparam int unsigned OUT_SLOT_W  = 4;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_RESULTS);

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_POLL    = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_FULL     = 3'd1,
    ST_FIRED    = 3'd2,
    ST_NONE     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_POLL,
    S_FLUSH
  } state_e;

  // slot table command from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic              free_en;
    logic              clr_en;
    logic [SLOT_W-1:0] idx;
  } store_cmd_t;

  // request to the shared adder
  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    status_e                status;
    logic [HANDLER_W-1:0]   handler;
    logic [ARG_W-1:0]       argument;
    logic [OUT_SLOT_W-1:0]  slot;
    logic                   last;
  } result_t;

  // slot number masked to the output field width
  function automatic logic [OUT_SLOT_W-1:0] slot_to_out(input logic [SLOT_W-1:0] s);
    logic [63:0] wide;
    wide = 64'(s);
    return wide[OUT_SLOT_W-1:0];
  endfunction

  function automatic result_t make_result(input status_e st,
                                          input logic [HANDLER_W-1:0] h,
                                          input logic [ARG_W-1:0] arg,
                                          input logic [OUT_SLOT_W-1:0] slot);
    result_t r;
    r.status   = st;
    r.handler  = h;
    r.argument = arg;
    r.slot     = slot;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

/* design/tet_alu.sv */
// shared 64-bit adder: expiry sum on enqueue, expiry compare on poll
module tet_alu (
  input  tet_pkg::alu_req_t              req_i,
  output logic [tet_pkg::TIME_W-1:0]     sum_o,
  output logic                           carry_o
);

  logic [tet_pkg::TIME_W-1:0] b_mod;

  // subtract as a plus inverted b plus one; carry out low means a < b
  assign b_mod = req_i.b ^ {tet_pkg::TIME_W{req_i.sub}};
  assign {carry_o, sum_o} = {1'b0, req_i.a} + {1'b0, b_mod}
                          + (tet_pkg::TIME_W + 1)'(req_i.sub);

endmodule

/* design/tet_store.sv */
// slot table: busy flags plus handler, argument and expiry per slot
module tet_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tet_pkg::store_cmd_t               cmd_i,
  input  logic [tet_pkg::HANDLER_W-1:0]     wr_handler_i,
  input  logic [tet_pkg::ARG_W-1:0]         wr_argument_i,
  input  logic [tet_pkg::TIME_W-1:0]        wr_expiry_i,
  output logic                              rd_busy_o,
  output logic [tet_pkg::HANDLER_W-1:0]     rd_handler_o,
  output logic [tet_pkg::ARG_W-1:0]         rd_argument_o,
  output logic [tet_pkg::TIME_W-1:0]        rd_expiry_o
);

  logic [tet_pkg::SLOTS-1:0]     busy_q, busy_d;
  logic [tet_pkg::HANDLER_W-1:0] handler_q [tet_pkg::SLOTS];
  logic [tet_pkg::ARG_W-1:0]     argument_q [tet_pkg::SLOTS];
  logic [tet_pkg::TIME_W-1:0]    expiry_q [tet_pkg::SLOTS];

  // busy flag update
  always_comb begin
    busy_d = busy_q;
    if (cmd_i.clr_en) begin
      busy_d = '0;
    end else begin
      if (cmd_i.wr_en) busy_d[cmd_i.idx] = 1'b1;
      if (cmd_i.free_en) busy_d[cmd_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // slot payload, written on enqueue
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      handler_q[cmd_i.idx]  <= wr_handler_i;
      argument_q[cmd_i.idx] <= wr_argument_i;
      expiry_q[cmd_i.idx]   <= wr_expiry_i;
    end
  end

  // read at the scan pointer
  assign rd_busy_o     = busy_q[cmd_i.idx];
  assign rd_handler_o  = handler_q[cmd_i.idx];
  assign rd_argument_o = argument_q[cmd_i.idx];
  assign rd_expiry_o   = expiry_q[cmd_i.idx];

endmodule

/* design/tet_ctrl.sv */
// sequencer: takes an item, one slot per cycle unless held, builds results
module tet_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [tet_pkg::HANDLER_W-1:0]     handler_id_i,
  input  logic [tet_pkg::ARG_W-1:0]         argument_i,
  input  logic [tet_pkg::TIME_W-1:0]        delay_i,
  input  logic [tet_pkg::TIME_W-1:0]        now_time_i,
  // slot table
  output tet_pkg::store_cmd_t               cmd_o,
  output logic [tet_pkg::HANDLER_W-1:0]     wr_handler_o,
  output logic [tet_pkg::ARG_W-1:0]         wr_argument_o,
  input  logic                              rd_busy_i,
  input  logic [tet_pkg::HANDLER_W-1:0]     rd_handler_i,
  input  logic [tet_pkg::ARG_W-1:0]         rd_argument_i,
  input  logic [tet_pkg::TIME_W-1:0]        rd_expiry_i,
  // shared adder
  output tet_pkg::alu_req_t                 alu_req_o,
  input  logic                              alu_carry_i,
  // result hand-off to the output register
  input  logic                              out_free_i,
  output logic                              push_o,
  output tet_pkg::result_t                  push_res_o
);

  tet_pkg::state_e               state_q, state_d;
  logic [tet_pkg::SLOT_W-1:0]    idx_q, idx_d;
  logic [tet_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          pend_valid_q, pend_valid_d;
  tet_pkg::result_t              pend_q, pend_d;
  logic [tet_pkg::HANDLER_W-1:0] handler_q, handler_d;
  logic [tet_pkg::ARG_W-1:0]     arg_q, arg_d;
  logic [tet_pkg::TIME_W-1:0]    delay_q, delay_d;
  logic [tet_pkg::TIME_W-1:0]    now_q, now_d;

  logic accept;
  logic is_last_slot;
  logic expired;
  logic fire;
  logic poll_wait;

  assign in_stall_o   = (state_q != tet_pkg::S_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign is_last_slot = (idx_q == tet_pkg::SLOT_LAST);

  // expiry < now when the subtract borrows
  assign expired   = !alu_carry_i;
  assign fire      = rd_busy_i && expired && (cnt_q < tet_pkg::CNT_MAX);
  // a second fire needs the earlier one moved out first
  assign poll_wait = fire && pend_valid_q && !out_free_i;

  assign alu_req_o.sub = (state_q == tet_pkg::S_POLL);
  assign alu_req_o.a   = alu_req_o.sub ? rd_expiry_i : now_q;
  assign alu_req_o.b   = alu_req_o.sub ? now_q : delay_q;

  assign wr_handler_o  = handler_q;
  assign wr_argument_o = arg_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tet_pkg::S_IDLE: begin
        if (accept) begin
          case (action_i)
            tet_pkg::ACT_ENQUEUE: state_d = tet_pkg::S_ENQ;
            tet_pkg::ACT_POLL:    state_d = tet_pkg::S_POLL;
            tet_pkg::ACT_CLEAR:   state_d = tet_pkg::S_FLUSH;
            default:              state_d = tet_pkg::S_IDLE;
          endcase
        end
      end
      tet_pkg::S_ENQ: begin
        if (!rd_busy_i || is_last_slot) state_d = tet_pkg::S_FLUSH;
      end
      tet_pkg::S_POLL: begin
        if (!poll_wait && is_last_slot) state_d = tet_pkg::S_FLUSH;
      end
      tet_pkg::S_FLUSH: begin
        if (out_free_i) state_d = tet_pkg::S_IDLE;
      end
      default: state_d = tet_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    handler_d     = handler_q;
    arg_d         = arg_q;
    delay_d       = delay_q;
    now_d         = now_q;
    cmd_o.wr_en   = 1'b0;
    cmd_o.free_en = 1'b0;
    cmd_o.clr_en  = 1'b0;
    cmd_o.idx     = idx_q;
    push_o        = 1'b0;
    push_res_o    = pend_q;
    unique case (state_q)
      tet_pkg::S_IDLE: begin
        if (accept) begin
          handler_d    = handler_id_i;
          arg_d        = argument_i;
          delay_d      = delay_i;
          now_d        = now_time_i;
          idx_d        = '0;
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          if (action_i == tet_pkg::ACT_CLEAR) begin
            cmd_o.clr_en = 1'b1;
            pend_d = tet_pkg::make_result(tet_pkg::ST_CLEARED, '0, '0, '0);
          end
        end
      end
      // first free slot search
      tet_pkg::S_ENQ: begin
        if (!rd_busy_i) begin
          cmd_o.wr_en = 1'b1;
          pend_d = tet_pkg::make_result(tet_pkg::ST_ENQUEUED, '0, '0,
                                        tet_pkg::slot_to_out(idx_q));
        end else if (is_last_slot) begin
          pend_d = tet_pkg::make_result(tet_pkg::ST_FULL, '0, '0, '0);
        end else begin
          idx_d = idx_q + tet_pkg::SLOT_W'(1);
        end
      end
      // expiry scan; each fire is held until the next one or the end
      tet_pkg::S_POLL: begin
        if (!poll_wait) begin
          if (fire) begin
            if (pend_valid_q) begin
              push_o          = 1'b1;
              push_res_o.last = 1'b0;
            end
            pend_d = tet_pkg::make_result(tet_pkg::ST_FIRED, rd_handler_i,
                                          rd_argument_i,
                                          tet_pkg::slot_to_out(idx_q));
            pend_valid_d  = 1'b1;
            cmd_o.free_en = 1'b1;
            cnt_d         = cnt_q + tet_pkg::CNT_W'(1);
          end
          if (is_last_slot) begin
            if (!fire && !pend_valid_q) begin
              pend_d = tet_pkg::make_result(tet_pkg::ST_NONE, '0, '0, '0);
            end
          end else begin
            idx_d = idx_q + tet_pkg::SLOT_W'(1);
          end
        end
      end
      // final result of the item
      tet_pkg::S_FLUSH: begin
        push_res_o.last = 1'b1;
        if (out_free_i) push_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tet_pkg::S_IDLE;
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // item and pending result payload
  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    handler_q <= handler_d;
    arg_q     <= arg_d;
    delay_q   <= delay_d;
    now_q     <= now_d;
  end

endmodule

/* design/timeout_event_table_core.sv */
// top level of the timeout event table
//
// input channel: in_valid_i / in_stall_o with action_i, handler_id_i,
// argument_i, delay_i and now_time_i. a transfer happens when valid is high
// and stall is low. output channel: out_valid_o / out_stall_i carrying
// status_o, fired_handler_o, fired_argument_o, slot_index_o and last_o.
//
// one item is worked on at a time; stall stays high until its last result
// has gone into the output register. a single 64-bit adder serves both the
// expiry sum and the expiry compare, and the sequencer visits one slot per
// cycle while no fired slot waits on a stalled result register. enqueue
// scans up to the first free slot, poll scans every slot, clear frees all
// slots at once. unused action code 3 is dropped with no result. a poll
// emits one result per fired slot, last_o on the final one, or a single
// none result when no slot fires.
// reset frees every slot at once; no clearing pass is needed. when the
// receiver stalls, the result register holds its contents and the scan
// pauses at the next fired slot until the register frees up.
module timeout_event_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [tet_pkg::HANDLER_W-1:0]     handler_id_i,
  input  logic [tet_pkg::ARG_W-1:0]         argument_i,
  input  logic [tet_pkg::TIME_W-1:0]        delay_i,
  input  logic [tet_pkg::TIME_W-1:0]        now_time_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        status_o,
  output logic [tet_pkg::HANDLER_W-1:0]     fired_handler_o,
  output logic [tet_pkg::ARG_W-1:0]         fired_argument_o,
  output logic [tet_pkg::OUT_SLOT_W-1:0]    slot_index_o,
  output logic                              last_o
);

  tet_pkg::store_cmd_t           cmd;
  tet_pkg::alu_req_t             alu_req;
  tet_pkg::result_t              push_res;
  tet_pkg::result_t              out_q;
  logic [tet_pkg::HANDLER_W-1:0] wr_handler;
  logic [tet_pkg::ARG_W-1:0]     wr_argument;
  logic                          rd_busy;
  logic [tet_pkg::HANDLER_W-1:0] rd_handler;
  logic [tet_pkg::ARG_W-1:0]     rd_argument;
  logic [tet_pkg::TIME_W-1:0]    rd_expiry;
  logic [tet_pkg::TIME_W-1:0]    alu_sum;
  logic                          alu_carry;
  logic                          push;
  logic                          out_free;
  logic                          out_valid_q, out_valid_d;

  tet_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .handler_id_i  (handler_id_i),
    .argument_i    (argument_i),
    .delay_i       (delay_i),
    .now_time_i    (now_time_i),
    .cmd_o         (cmd),
    .wr_handler_o  (wr_handler),
    .wr_argument_o (wr_argument),
    .rd_busy_i     (rd_busy),
    .rd_handler_i  (rd_handler),
    .rd_argument_i (rd_argument),
    .rd_expiry_i   (rd_expiry),
    .alu_req_o     (alu_req),
    .alu_carry_i   (alu_carry),
    .out_free_i    (out_free),
    .push_o        (push),
    .push_res_o    (push_res)
  );

  tet_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .wr_handler_i  (wr_handler),
    .wr_argument_i (wr_argument),
    .wr_expiry_i   (alu_sum),
    .rd_busy_o     (rd_busy),
    .rd_handler_o  (rd_handler),
    .rd_argument_o (rd_argument),
    .rd_expiry_o   (rd_expiry)
  );

  tet_alu u_alu (
    .req_i   (alu_req),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) out_q <= push_res;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign fired_handler_o  = out_q.handler;
  assign fired_argument_o = out_q.argument;
  assign slot_index_o     = out_q.slot;
  assign last_o           = out_q.last;

endmodule

/* design/tet_checker.sv */
// port-level checks of the timeout event table, bound to the top level
`include "timeout_event_table_core_assert.svh"

module tet_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [1:0]                        action_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [2:0]                        status_o,
  input logic [tet_pkg::HANDLER_W-1:0]     fired_handler_o,
  input logic [tet_pkg::ARG_W-1:0]         fired_argument_o,
  input logic [tet_pkg::OUT_SLOT_W-1:0]    slot_index_o,
  input logic                              last_o
);

  logic in_xfer_valid_act;
  logic single_result;

  assign in_xfer_valid_act = in_valid_i && !in_stall_o &&
                             (action_i == tet_pkg::ACT_ENQUEUE ||
                              action_i == tet_pkg::ACT_POLL ||
                              action_i == tet_pkg::ACT_CLEAR);

  assign single_result = status_o == tet_pkg::ST_ENQUEUED ||
                         status_o == tet_pkg::ST_FULL ||
                         status_o == tet_pkg::ST_NONE ||
                         status_o == tet_pkg::ST_CLEARED;

  // stalled result holds
  `TET_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(slot_index_o) && $stable(last_o) &&
    $stable(fired_handler_o) && $stable(fired_argument_o),
    "stalled result changed")

  // a real action blocks further transfers while it is worked on
  `TET_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer_valid_act, in_stall_o,
    "input taken again before the item finished")

  `TET_ASSERT_SAME(a_status_range, clk_i, rst_ni, out_valid_o,
    status_o <= tet_pkg::ST_CLEARED, "status code out of range")

  // only fired results carry handler and argument
  `TET_ASSERT_SAME(a_zero_payload, clk_i, rst_ni,
    out_valid_o && status_o != tet_pkg::ST_FIRED,
    fired_handler_o == '0 && fired_argument_o == '0, "payload not zero")

  `TET_ASSERT_SAME(a_single_last, clk_i, rst_ni, out_valid_o && single_result,
    last_o, "single result without last")

endmodule

bind timeout_event_table_core tet_checker u_tet_checker (.*);
